FILE: design/sdct_pkg.sv
`timescale 1ns / 1ps
// sdct_pkg: constants, codes and tables for the serial date to civil time unit.
// No dependencies.
package sdct_pkg;

  // Field widths fixed by the stream format
  localparam int SERIAL_W = 55;
  localparam int YEAR_W   = 15;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;

  // Time of day
  localparam int SOD_W = 17;
  localparam logic [SOD_W-1:0] SEC_PER_DAY = 17'd86400;
  localparam logic [SOD_W-1:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [11:0] SEC_PER_MIN = 12'd60;

  // Calendar datapath: biased day count, always positive, below 2^40
  localparam int CAL_U_W = 40;
  localparam int ERA_Q_W = 23;
  localparam int DOE_W   = 18;
  localparam logic [DOE_W-1:0] ERA_DAYS = 18'd146097;
  localparam logic [YEAR_W-1:0] ERA_YEARS = 15'd400;
  localparam int FAKE_LEAP_DAY = 60;

  // Day count bias: epoch shift to 0000-03-01 plus 2^22 whole eras
  localparam logic [63:0] ERA_BIAS = 64'd146097 << 22;
  localparam logic [CAL_U_W-1:0] OFS_1900 = CAL_U_W'(64'd693900 + ERA_BIAS);
  localparam logic [CAL_U_W-1:0] OFS_1904 = CAL_U_W'(64'd695361 + ERA_BIAS);

  // Reciprocals: q = (x * M) >> S, M = ceil(2^S / d), S = xbits + clog2(d)
  localparam int ERA_SHIFT = 58;
  localparam logic [63:0] ERA_RECIP = ((64'd1 << ERA_SHIFT) + 64'd146096) / 64'd146097;
  localparam logic [20:0] ERA_RECIP_LO = ERA_RECIP[20:0];
  localparam logic [19:0] ERA_RECIP_HI = ERA_RECIP[40:21];

  localparam logic [18:0] RECIP_1460  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] RECIP_36524 = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
  localparam logic [18:0] RECIP_365   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [9:0]  RECIP_100   = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
  localparam logic [17:0] RECIP_3600  = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [12:0] RECIP_60    = 13'(((64'd1 << 18) + 64'd59) / 64'd60);

  // First day of each month in a March-based year
  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };

  // The non-existent 1900-02-29 of the 1900 system
  localparam logic [YEAR_W-1:0]  LEAP_BUG_YEAR  = 15'd1900;
  localparam logic [MONTH_W-1:0] LEAP_BUG_MONTH = 4'd2;
  localparam logic [DAY_W-1:0]   LEAP_BUG_DAY   = 5'd29;

  typedef enum logic {
    DATE_SYS_1900 = 1'b0,
    DATE_SYS_1904 = 1'b1
  } date_sys_e;

  typedef enum logic [1:0] {
    FMT_DATE      = 2'd0,
    FMT_TIME      = 2'd1,
    FMT_DATE_TIME = 2'd2
  } fmt_kind_e;

endpackage

FILE: design/serial_date_to_civil_time_unit.sv
`timescale 1ns / 1ps
// serial_date_to_civil_time_unit: pipelined serial day number to civil date and time.
// Depends on sdct_pkg.
//
//  channel  | direction | payload (lowest bit first)
//  ---------+-----------+-------------------------------------------------------
//  s_axis   | in        | tdata: serial_fixed; tuser: format_kind
//  m_axis   | out       | tdata: year, month, day, hour, minute, second;
//           |           | tuser: show_date, show_time
//  cfg      | in        | data: date_system
//
// Thirteen register stages; an item enters every cycle unless output back-pressure has filled them.
// The depth is set by the chain of constant divisions (seconds split, 400-year era,
// year of era, month), done by reciprocal multiplies and a month table search.
// Each stage advances when the stage after it is empty or advancing, so bubbles
// close up and input is taken while a result waits at the output, if a stage is empty.
// Reset clears the valid bits and sets the 1900 date system.
module serial_date_to_civil_time_unit #(
  parameter int FRACTION_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // [54:0] serial_fixed
  input  logic [1:0]  s_axis_tuser,   // [1:0] format_kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [14:0] year, [18:15] month, [23:19] day,
                                      // [28:24] hour, [34:29] minute, [40:35] second
  output logic [1:0]  m_axis_tuser,   // [0] show_date, [1] show_time
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i      // date_system
);
  import sdct_pkg::*;

  localparam int NST     = 13;
  localparam int LAST    = NST - 1;
  localparam int WHOLE_W = SERIAL_W - FRACTION_BITS;
  localparam int SDAY_W  = WHOLE_W + 1;
  localparam int FPROD_W = FRACTION_BITS + SOD_W;
  localparam logic [FPROD_W-1:0] HALF_SEC = FPROD_W'(1) << (FRACTION_BITS - 1);
  localparam logic signed [SDAY_W-1:0] LEAP_SDAY = SDAY_W'(FAKE_LEAP_DAY);

  typedef struct packed {
    logic                     neg;
    logic [WHOLE_W-1:0]       whole;
    logic [FRACTION_BITS-1:0] frac;
    logic [SOD_W-1:0]         fsec;
    logic [SDAY_W-1:0]        sday;
    logic [SOD_W-1:0]         sod;
    logic [CAL_U_W-1:0]       ucnt;
    logic                     fake;
    logic [60:0]              ppl;
    logic [ERA_Q_W-1:0]       era_q;
    logic [HOUR_W-1:0]        hour;
    logic [11:0]              rem;
    logic [MIN_W-1:0]         minute;
    logic [SEC_W-1:0]         second;
    logic [DOE_W-1:0]         doe;
    logic [YEAR_W-1:0]        ybase;
    logic [6:0]               q1460;
    logic [2:0]               q36524;
    logic                     era_end;
    logic [DOE_W-1:0]         tdays;
    logic [8:0]               yoe;
    logic [1:0]               cent;
    logic [DOE_W-1:0]         ydays;
    logic [8:0]               doy;
    logic [YEAR_W-1:0]        year;
    logic [MONTH_W-1:0]       month;
    logic [DAY_W-1:0]         day;
    logic                     show_date;
    logic                     show_time;
  } stage_t;

  stage_t           st_q [NST];
  stage_t           st_d [NST];
  logic [NST-1:0]   vld_q;
  logic [NST-1:0]   adv;
  date_sys_e        date_sys_q;

  // Datapath temporaries
  logic [SERIAL_W-1:0]      raw;
  logic [SERIAL_W-1:0]      mag;
  logic [FPROD_W-1:0]       fprod;
  logic [FPROD_W-1:0]       fround;
  logic [SDAY_W-1:0]        wext;
  logic                     fsec_zero;
  logic                     fsec_full;
  logic [CAL_U_W-1:0]       sday_ext;
  logic                     after_leap;
  logic [34:0]              phour;
  logic [60:0]              plo;
  logic [SOD_W-1:0]         hour_sec;
  logic [SOD_W-1:0]         rem_full;
  logic [59:0]              phi;
  logic [80:0]              eprod;
  logic [24:0]              pmin;
  logic [DOE_W-1:0]         qdays;
  logic [11:0]              min_sec;
  logic [11:0]              sec_full;
  logic [36:0]              p1460;
  logic [36:0]              p36524;
  logic [36:0]              p365;
  logic [18:0]              p100;
  logic [DOE_W-1:0]         y365;
  logic [DOE_W-1:0]         doy_full;
  logic [3:0]               mp;
  logic [8:0]               day_full;

  // Config register, write always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      date_sys_q <= DATE_SYS_1900;
    end else if (cfg_valid_i) begin
      date_sys_q <= date_sys_e'(cfg_data_i);
    end
  end

  // Stage enables: a stage moves when the next one is empty or moving
  always_comb begin
    adv[LAST] = !vld_q[LAST] || m_axis_tready;
    for (int k = LAST - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign s_axis_tready = adv[0];

  // Stage logic
  always_comb begin
    // stage 0: magnitude and split into whole days and fraction
    raw = s_axis_tdata[SERIAL_W-1:0];
    mag = raw[SERIAL_W-1] ? (~raw + SERIAL_W'(1)) : raw;
    st_d[0] = '0;
    st_d[0].neg   = raw[SERIAL_W-1];
    st_d[0].whole = mag[SERIAL_W-1:FRACTION_BITS];
    st_d[0].frac  = mag[FRACTION_BITS-1:0];
    unique case (fmt_kind_e'(s_axis_tuser))
      FMT_DATE: begin
        st_d[0].show_date = 1'b1;
        st_d[0].show_time = 1'b0;
      end
      FMT_TIME: begin
        st_d[0].show_date = 1'b0;
        st_d[0].show_time = 1'b1;
      end
      FMT_DATE_TIME: begin
        st_d[0].show_date = 1'b1;
        st_d[0].show_time = 1'b1;
      end
      default: begin
        st_d[0].show_date = 1'b0;
        st_d[0].show_time = 1'b0;
      end
    endcase

    // stage 1: fraction to seconds, half away from zero (on the magnitude)
    fprod = st_q[0].frac * SEC_PER_DAY;
    fround = fprod + HALF_SEC;
    st_d[1] = st_q[0];
    st_d[1].fsec = fround[FPROD_W-1:FRACTION_BITS];

    // stage 2: floored day and second of day
    wext = {1'b0, st_q[1].whole};
    fsec_zero = (st_q[1].fsec == '0);
    fsec_full = (st_q[1].fsec == SEC_PER_DAY);
    st_d[2] = st_q[1];
    if (st_q[1].neg) begin
      st_d[2].sday = ~wext + SDAY_W'(fsec_zero);
    end else begin
      st_d[2].sday = wext + SDAY_W'(fsec_full);
    end
    if (fsec_zero || fsec_full) begin
      st_d[2].sod = '0;
    end else if (st_q[1].neg) begin
      st_d[2].sod = SEC_PER_DAY - st_q[1].fsec;
    end else begin
      st_d[2].sod = st_q[1].fsec;
    end

    // stage 3: biased day count for the date system, hour
    sday_ext = {{(CAL_U_W - SDAY_W){st_q[2].sday[SDAY_W-1]}}, st_q[2].sday};
    after_leap = ($signed(st_q[2].sday) > LEAP_SDAY);
    st_d[3] = st_q[2];
    st_d[3].fake = 1'b0;
    if (date_sys_q == DATE_SYS_1904) begin
      st_d[3].ucnt = sday_ext + OFS_1904;
    end else begin
      st_d[3].fake = ($signed(st_q[2].sday) == LEAP_SDAY);
      st_d[3].ucnt = sday_ext + OFS_1900 - CAL_U_W'(after_leap);
    end
    phour = st_q[2].sod * RECIP_3600;
    st_d[3].hour = phour[29 +: HOUR_W];

    // stage 4: era quotient, low partial product; seconds within the hour
    plo = st_q[3].ucnt * ERA_RECIP_LO;
    hour_sec = st_q[3].hour * SEC_PER_HOUR;
    rem_full = st_q[3].sod - hour_sec;
    st_d[4] = st_q[3];
    st_d[4].ppl = plo;
    st_d[4].rem = rem_full[11:0];

    // stage 5: era quotient, high partial product and sum; minute
    phi = st_q[4].ucnt * ERA_RECIP_HI;
    eprod = {20'b0, st_q[4].ppl} + {phi, 21'b0};
    pmin = st_q[4].rem * RECIP_60;
    st_d[5] = st_q[4];
    st_d[5].era_q = eprod[ERA_SHIFT +: ERA_Q_W];
    st_d[5].minute = pmin[18 +: MIN_W];

    // stage 6: day of era, year base of era; second
    qdays = st_q[5].era_q[DOE_W-1:0] * ERA_DAYS;
    min_sec = st_q[5].minute * SEC_PER_MIN;
    sec_full = st_q[5].rem - min_sec;
    st_d[6] = st_q[5];
    st_d[6].doe = st_q[5].ucnt[DOE_W-1:0] - qdays;
    st_d[6].ybase = st_q[5].era_q[YEAR_W-1:0] * ERA_YEARS;
    st_d[6].second = sec_full[SEC_W-1:0];

    // stage 7: leap corrections within the era
    p1460 = st_q[6].doe * RECIP_1460;
    p36524 = st_q[6].doe * RECIP_36524;
    st_d[7] = st_q[6];
    st_d[7].q1460 = p1460[29 +: 7];
    st_d[7].q36524 = p36524[34 +: 3];
    st_d[7].era_end = (st_q[6].doe == ERA_DAYS - DOE_W'(1));

    // stage 8: corrected day count
    st_d[8] = st_q[7];
    st_d[8].tdays = st_q[7].doe - DOE_W'(st_q[7].q1460) + DOE_W'(st_q[7].q36524)
                    - DOE_W'(st_q[7].era_end);

    // stage 9: year of era
    p365 = st_q[8].tdays * RECIP_365;
    st_d[9] = st_q[8];
    st_d[9].yoe = p365[27 +: 9];

    // stage 10: days before the year
    p100 = st_q[9].yoe * RECIP_100;
    y365 = st_q[9].yoe * DOE_W'(365);
    st_d[10] = st_q[9];
    st_d[10].cent = p100[16 +: 2];
    st_d[10].ydays = y365 + DOE_W'(st_q[9].yoe >> 2);

    // stage 11: day of March-based year
    doy_full = st_q[10].doe - st_q[10].ydays + DOE_W'(st_q[10].cent);
    st_d[11] = st_q[10];
    st_d[11].doy = doy_full[8:0];

    // stage 12: month, day, year; the 1900 leap bug day overrides
    mp = '0;
    for (int i = 1; i < 12; i++) begin
      if (st_q[11].doy >= MONTH_START[i]) begin
        mp = 4'(i);
      end
    end
    day_full = st_q[11].doy - MONTH_START[mp] + 9'd1;
    st_d[12] = st_q[11];
    if (st_q[11].fake) begin
      st_d[12].year  = LEAP_BUG_YEAR;
      st_d[12].month = LEAP_BUG_MONTH;
      st_d[12].day   = LEAP_BUG_DAY;
    end else begin
      st_d[12].year  = st_q[11].ybase + YEAR_W'(st_q[11].yoe) + YEAR_W'(mp >= 4'd10);
      st_d[12].month = (mp < 4'd10) ? (mp + 4'd3) : (mp - 4'd9);
      st_d[12].day   = day_full[DAY_W-1:0];
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NST; k++) begin
      if (adv[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // Output item
  assign m_axis_tvalid = vld_q[LAST];
  assign m_axis_tdata = {7'b0, st_q[LAST].second, st_q[LAST].minute, st_q[LAST].hour,
                         st_q[LAST].day, st_q[LAST].month, st_q[LAST].year};
  assign m_axis_tuser = {st_q[LAST].show_time, st_q[LAST].show_date};

endmodule
